// ===== src/pmr_pkg.sv =====
package pmr_pkg;

    // default sizes of the register arrays
    localparam int COMMAND_WORDS_DEF = 32;
    localparam int PIN_BANKS_DEF     = 4;

    // the only access size that is served
    localparam logic [2:0] ACCESS_WORD = 3'd4;

    // register select codes
    typedef logic [4:0] t_sel;
    localparam t_sel SEL_NONE         = 5'd0;
    localparam t_sel SEL_MODE         = 5'd1;
    localparam t_sel SEL_SLEEP_STAT   = 5'd2;
    localparam t_sel SEL_SCRATCH      = 5'd3;
    localparam t_sel SEL_WAKE_EN      = 5'd4;
    localparam t_sel SEL_RISE_EN      = 5'd5;
    localparam t_sel SEL_FALL_EN      = 5'd6;
    localparam t_sel SEL_EDGE_DET     = 5'd7;
    localparam t_sel SEL_GEN_SETUP    = 5'd8;
    localparam t_sel SEL_PIN_LEVEL    = 5'd9;
    localparam t_sel SEL_RESET_CAUSE  = 5'd10;
    localparam t_sel SEL_FAST_WAKE    = 5'd11;
    localparam t_sel SEL_SLEEP_TIMING = 5'd12;
    localparam t_sel SEL_VOLTAGE      = 5'd13;
    localparam t_sel SEL_PWR_IO       = 5'd14;
    localparam t_sel SEL_KEY_EN       = 5'd15;
    localparam t_sel SEL_KEY_STAT     = 5'd16;
    localparam t_sel SEL_CMD          = 5'd17;

    // write masks, newer and older variant
    localparam logic [31:0] MASK_MODE_NEW    = 32'h0000_003f;
    localparam logic [31:0] MASK_MODE_OLD    = 32'h0000_0001;
    localparam logic [31:0] MASK_FULL        = 32'hffff_ffff;
    localparam logic [31:0] MASK_WAKE_NEW    = 32'hdf9f_fe1b;
    localparam logic [31:0] MASK_WAKE_OLD    = 32'hf000_ffff;
    localparam logic [31:0] MASK_EDGE_NEW    = 32'h0100_fe1b;
    localparam logic [31:0] MASK_EDGE_OLD    = 32'h0000_ffff;
    localparam logic [31:0] MASK_GEN_NEW     = 32'h0000_dcd7;
    localparam logic [31:0] MASK_GEN_OLD     = 32'h0000_0007;
    localparam logic [31:0] MASK_PIN_TOP     = 32'h01ff_ffff;
    localparam logic [31:0] MASK_FAST_NEW    = 32'hffd0_0f0c;
    localparam logic [31:0] MASK_FAST_OLD    = 32'h0000_0002;
    localparam logic [31:0] MASK_TIMING      = 32'h0000_0f0c;
    localparam logic [31:0] MASK_VOLTAGE     = 32'h01f0_4fff;
    localparam logic [31:0] MASK_PWR_IO      = 32'h0000_002d;
    localparam logic [31:0] MASK_KEY_EN      = 32'h000f_ffff;
    localparam logic [31:0] MASK_CMD         = 32'h0000_1fff;

    // reset values
    localparam logic [31:0] RST_SLEEP_STAT   = 32'h0000_0020;
    localparam logic [31:0] RST_EDGE_EN      = 32'h0000_0003;
    localparam logic [31:0] RST_RESET_CAUSE  = 32'h0000_0001;
    localparam logic [31:0] RST_FAST_WAKE    = 32'hcc00_0000;

    // decode result handed to the register file
    typedef struct packed {
        logic        err;
        t_sel        sel;
        logic        w1c;
        logic [31:0] mask;
    } t_dec;

endpackage

// ===== src/pmr_decode.sv =====
module pmr_decode #(
    parameter int COMMAND_WORDS = pmr_pkg::COMMAND_WORDS_DEF,
    parameter int PIN_BANKS     = pmr_pkg::PIN_BANKS_DEF
) (
    input  logic          i_newer_variant,
    input  logic [6:0]    i_word_index,
    input  logic [2:0]    i_access_bytes,
    output pmr_pkg::t_dec o_dec
);

    logic       nv;
    logic [1:0] bank;
    logic [4:0] cmd_ofs;

    assign nv      = i_newer_variant;
    assign bank    = i_word_index[1:0];
    assign cmd_ofs = i_word_index[4:0];

    // word map decode with variant gating
    always_comb begin
        o_dec.err  = 1'b0;
        o_dec.sel  = pmr_pkg::SEL_NONE;
        o_dec.w1c  = 1'b0;
        o_dec.mask = pmr_pkg::MASK_FULL;
        case (i_word_index) inside
            7'd0: begin
                o_dec.sel  = pmr_pkg::SEL_MODE;
                o_dec.mask = nv ? pmr_pkg::MASK_MODE_NEW : pmr_pkg::MASK_MODE_OLD;
            end
            7'd1: begin
                o_dec.sel = pmr_pkg::SEL_SLEEP_STAT;
                o_dec.w1c = 1'b1;
            end
            7'd2: o_dec.sel = pmr_pkg::SEL_SCRATCH;
            7'd3: begin
                o_dec.sel  = pmr_pkg::SEL_WAKE_EN;
                o_dec.mask = nv ? pmr_pkg::MASK_WAKE_NEW : pmr_pkg::MASK_WAKE_OLD;
            end
            7'd4: begin
                o_dec.sel  = pmr_pkg::SEL_RISE_EN;
                o_dec.mask = nv ? pmr_pkg::MASK_EDGE_NEW : pmr_pkg::MASK_EDGE_OLD;
            end
            7'd5: begin
                o_dec.sel  = pmr_pkg::SEL_FALL_EN;
                o_dec.mask = nv ? pmr_pkg::MASK_EDGE_NEW : pmr_pkg::MASK_EDGE_OLD;
            end
            7'd6: begin
                o_dec.sel = pmr_pkg::SEL_EDGE_DET;
                o_dec.w1c = 1'b1;
            end
            7'd7: begin
                o_dec.sel  = pmr_pkg::SEL_GEN_SETUP;
                o_dec.mask = nv ? pmr_pkg::MASK_GEN_NEW : pmr_pkg::MASK_GEN_OLD;
            end
            [7'd8:7'd11]: begin
                // top bank only on the newer variant
                if (32'(bank) >= PIN_BANKS || (bank == 2'd3 && !nv)) begin
                    o_dec.err = 1'b1;
                end else begin
                    o_dec.sel  = pmr_pkg::SEL_PIN_LEVEL;
                    o_dec.mask = (bank == 2'd3) ? pmr_pkg::MASK_PIN_TOP : pmr_pkg::MASK_FULL;
                end
            end
            7'd12: begin
                o_dec.sel = pmr_pkg::SEL_RESET_CAUSE;
                o_dec.w1c = 1'b1;
            end
            7'd13: begin
                o_dec.sel  = pmr_pkg::SEL_FAST_WAKE;
                o_dec.mask = nv ? pmr_pkg::MASK_FAST_NEW : pmr_pkg::MASK_FAST_OLD;
            end
            7'd14: begin
                o_dec.err  = !nv;
                o_dec.sel  = pmr_pkg::SEL_SLEEP_TIMING;
                o_dec.mask = pmr_pkg::MASK_TIMING;
            end
            7'd16: begin
                o_dec.err  = !nv;
                o_dec.sel  = pmr_pkg::SEL_VOLTAGE;
                o_dec.mask = pmr_pkg::MASK_VOLTAGE;
            end
            7'd19: begin
                o_dec.err  = !nv;
                o_dec.sel  = pmr_pkg::SEL_PWR_IO;
                o_dec.mask = pmr_pkg::MASK_PWR_IO;
            end
            7'd20: begin
                o_dec.err  = !nv;
                o_dec.sel  = pmr_pkg::SEL_KEY_EN;
                o_dec.mask = pmr_pkg::MASK_KEY_EN;
            end
            7'd21: begin
                o_dec.err = !nv;
                o_dec.sel = pmr_pkg::SEL_KEY_STAT;
                o_dec.w1c = 1'b1;
            end
            [7'd32:7'd63]: begin
                o_dec.err  = !nv || (32'(cmd_ofs) >= COMMAND_WORDS);
                o_dec.sel  = pmr_pkg::SEL_CMD;
                o_dec.mask = pmr_pkg::MASK_CMD;
            end
            default: o_dec.err = 1'b1;
        endcase

        // only word accesses are served
        if (i_access_bytes != pmr_pkg::ACCESS_WORD) begin
            o_dec.err = 1'b1;
        end
        if (o_dec.err) begin
            o_dec.sel = pmr_pkg::SEL_NONE;
        end
    end

endmodule

// ===== src/pmr_regs.sv =====
module pmr_regs #(
    parameter int COMMAND_WORDS = pmr_pkg::COMMAND_WORDS_DEF,
    parameter int PIN_BANKS     = pmr_pkg::PIN_BANKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_is_write,
    input  logic [6:0]    i_word_index,
    input  logic [31:0]   i_write_data,
    input  pmr_pkg::t_dec i_dec,
    output logic [31:0]   o_read_value
);

    localparam int CMD_IW = (COMMAND_WORDS > 1) ? $clog2(COMMAND_WORDS) : 1;
    localparam int PIN_IW = $clog2(PIN_BANKS);

    logic [5:0]  r_mode;
    logic [31:0] r_sleep_stat;
    logic [31:0] r_scratch;
    logic [31:0] r_wake_en;
    logic [31:0] r_rise_en;
    logic [31:0] r_fall_en;
    logic [31:0] r_edge_det;
    logic [15:0] r_gen_setup;
    logic [31:0] r_pin_level [PIN_BANKS];
    logic [31:0] r_reset_cause;
    logic [31:0] r_fast_wake;
    logic [11:0] r_sleep_timing;
    logic [24:0] r_voltage;
    logic [5:0]  r_pwr_io;
    logic [19:0] r_key_en;
    logic [31:0] r_key_stat;
    logic [12:0] r_cmd [COMMAND_WORDS];

    logic              we;
    logic [31:0]       wd;
    logic [31:0]       clr;
    logic [PIN_IW-1:0] pin_idx;
    logic [CMD_IW-1:0] cmd_idx;

    assign we      = i_req_valid && i_is_write && !i_dec.err;
    assign wd      = i_write_data & i_dec.mask;
    // clear mask, only status registers clear on a written one
    assign clr     = i_dec.w1c ? ~i_write_data : '1;
    assign pin_idx = i_word_index[PIN_IW-1:0];
    assign cmd_idx = i_word_index[CMD_IW-1:0];

    // register updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= '0;
            r_sleep_stat   <= pmr_pkg::RST_SLEEP_STAT;
            r_scratch      <= '0;
            r_wake_en      <= pmr_pkg::RST_EDGE_EN;
            r_rise_en      <= pmr_pkg::RST_EDGE_EN;
            r_fall_en      <= pmr_pkg::RST_EDGE_EN;
            r_edge_det     <= '0;
            r_gen_setup    <= '0;
            r_reset_cause  <= pmr_pkg::RST_RESET_CAUSE;
            r_fast_wake    <= pmr_pkg::RST_FAST_WAKE;
            r_sleep_timing <= '0;
            r_voltage      <= '0;
            r_pwr_io       <= '0;
            r_key_en       <= '0;
            r_key_stat     <= '0;
            for (int b = 0; b < PIN_BANKS; b++) begin
                r_pin_level[b] <= '0;
            end
            for (int c = 0; c < COMMAND_WORDS; c++) begin
                r_cmd[c] <= '0;
            end
        end else if (we) begin
            case (i_dec.sel)
                pmr_pkg::SEL_MODE:         r_mode         <= wd[5:0];
                pmr_pkg::SEL_SLEEP_STAT:   r_sleep_stat   <= r_sleep_stat & clr;
                pmr_pkg::SEL_SCRATCH:      r_scratch      <= wd;
                pmr_pkg::SEL_WAKE_EN:      r_wake_en      <= wd;
                pmr_pkg::SEL_RISE_EN:      r_rise_en      <= wd;
                pmr_pkg::SEL_FALL_EN:      r_fall_en      <= wd;
                pmr_pkg::SEL_EDGE_DET:     r_edge_det     <= r_edge_det & clr;
                pmr_pkg::SEL_GEN_SETUP:    r_gen_setup    <= wd[15:0];
                pmr_pkg::SEL_PIN_LEVEL:    r_pin_level[pin_idx] <= wd;
                pmr_pkg::SEL_RESET_CAUSE:  r_reset_cause  <= r_reset_cause & clr;
                pmr_pkg::SEL_FAST_WAKE:    r_fast_wake    <= wd;
                pmr_pkg::SEL_SLEEP_TIMING: r_sleep_timing <= wd[11:0];
                pmr_pkg::SEL_VOLTAGE:      r_voltage      <= wd[24:0];
                pmr_pkg::SEL_PWR_IO:       r_pwr_io       <= wd[5:0];
                pmr_pkg::SEL_KEY_EN:       r_key_en       <= wd[19:0];
                pmr_pkg::SEL_KEY_STAT:     r_key_stat     <= r_key_stat & clr;
                pmr_pkg::SEL_CMD:          r_cmd[cmd_idx] <= wd[12:0];
                default: ;
            endcase
        end
    end

    // read mux, zero for rejected accesses
    always_comb begin
        case (i_dec.sel)
            pmr_pkg::SEL_MODE:         o_read_value = 32'(r_mode);
            pmr_pkg::SEL_SLEEP_STAT:   o_read_value = r_sleep_stat;
            pmr_pkg::SEL_SCRATCH:      o_read_value = r_scratch;
            pmr_pkg::SEL_WAKE_EN:      o_read_value = r_wake_en;
            pmr_pkg::SEL_RISE_EN:      o_read_value = r_rise_en;
            pmr_pkg::SEL_FALL_EN:      o_read_value = r_fall_en;
            pmr_pkg::SEL_EDGE_DET:     o_read_value = r_edge_det;
            pmr_pkg::SEL_GEN_SETUP:    o_read_value = 32'(r_gen_setup);
            pmr_pkg::SEL_PIN_LEVEL:    o_read_value = r_pin_level[pin_idx];
            pmr_pkg::SEL_RESET_CAUSE:  o_read_value = r_reset_cause;
            pmr_pkg::SEL_FAST_WAKE:    o_read_value = r_fast_wake;
            pmr_pkg::SEL_SLEEP_TIMING: o_read_value = 32'(r_sleep_timing);
            pmr_pkg::SEL_VOLTAGE:      o_read_value = 32'(r_voltage);
            pmr_pkg::SEL_PWR_IO:       o_read_value = 32'(r_pwr_io);
            pmr_pkg::SEL_KEY_EN:       o_read_value = 32'(r_key_en);
            pmr_pkg::SEL_KEY_STAT:     o_read_value = r_key_stat;
            pmr_pkg::SEL_CMD:          o_read_value = 32'(r_cmd[cmd_idx]);
            default:                   o_read_value = '0;
        endcase
    end

endmodule

// ===== src/power_manager_register_block.sv =====
// power manager register block
//
// access channel: drive i_start with i_is_write, i_word_index, i_access_bytes
// and i_write_data; the transaction is taken at a rising edge with i_start high
// and o_busy low. o_busy stays low, so one access can be issued every cycle.
// results: o_done is high for exactly one cycle with o_read_data and
// o_access_error; the receiver cannot stall, so no result is ever held back.
// from accept to o_done an access passes the input register, then decode,
// register update and the result register; throughput is one access per cycle,
// set by the single decode and read mux between the two register stages.
// reads of rejected accesses and all writes return zero data.
// configuration: i_cfg_valid/o_cfg_ready with i_cfg_data selects the newer
// variant; o_cfg_ready is always high, write it only while no access is in
// flight.
// reset (i_rst_n low, synchronous): the register file returns to its defaults,
// the newer variant is selected and no result is pending.
module power_manager_register_block #(
    parameter int COMMAND_WORDS = pmr_pkg::COMMAND_WORDS_DEF,
    parameter int PIN_BANKS     = pmr_pkg::PIN_BANKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_is_write,
    input  logic [6:0]  i_word_index,
    input  logic [2:0]  i_access_bytes,
    input  logic [31:0] i_write_data,
    output logic        o_done,
    output logic [31:0] o_read_data,
    output logic        o_access_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    logic          r_newer_variant;
    logic          r_req_valid;
    logic          r_is_write;
    logic [6:0]    r_word_index;
    logic [2:0]    r_access_bytes;
    logic [31:0]   r_write_data;
    logic          r_done;
    logic [31:0]   r_read_data;
    logic          r_access_error;
    logic [31:0]   n_read_data;
    logic [31:0]   read_value;
    pmr_pkg::t_dec dec;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // variant configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newer_variant <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_newer_variant <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_is_write     <= i_is_write;
            r_word_index   <= i_word_index;
            r_access_bytes <= i_access_bytes;
            r_write_data   <= i_write_data;
        end
    end

    pmr_decode #(
        .COMMAND_WORDS (COMMAND_WORDS),
        .PIN_BANKS     (PIN_BANKS)
    ) u_decode (
        .i_newer_variant (r_newer_variant),
        .i_word_index    (r_word_index),
        .i_access_bytes  (r_access_bytes),
        .o_dec           (dec)
    );

    pmr_regs #(
        .COMMAND_WORDS (COMMAND_WORDS),
        .PIN_BANKS     (PIN_BANKS)
    ) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (r_req_valid),
        .i_is_write   (r_is_write),
        .i_word_index (r_word_index),
        .i_write_data (r_write_data),
        .i_dec        (dec),
        .o_read_value (read_value)
    );

    // writes and rejected accesses return zero
    assign n_read_data = (r_is_write || dec.err) ? '0 : read_value;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_valid) begin
            r_read_data    <= n_read_data;
            r_access_error <= dec.err;
        end
    end

    assign o_done         = r_done;
    assign o_read_data    = r_read_data;
    assign o_access_error = r_access_error;

    // every accepted transaction gives one result in the cycle after r_req_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid |=> o_done)
        else $error("accepted access gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_req_valid |=> !o_done)
        else $error("result without an accepted access");

    // a rejected access never returns data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_access_error) |-> (o_read_data == 32'd0))
        else $error("rejected access returned data");

    // a write returns zero data
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && r_is_write) |=> (o_read_data == 32'd0))
        else $error("write returned data");

    // a non-word access is always rejected
    a_bad_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && r_access_bytes != pmr_pkg::ACCESS_WORD) |=> o_access_error)
        else $error("non-word access accepted");

endmodule
